### hw/rtl/scalar_kalman_smoother_defines.svh
// Assertion macros for the scalar Kalman smoother checker.
// Included by bare file name; needs nothing else.
`ifndef SCALAR_KALMAN_SMOOTHER_DEFINES_SVH
`define SCALAR_KALMAN_SMOOTHER_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define SKF_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define SKF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SKF_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/skf_pkg.sv
// Shared types and constants for the scalar Kalman smoother.
// No dependencies.
package skf_pkg;

   localparam int SAMPLE_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int EST_BITS = 32;
   localparam int VAR_BITS = 32;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CSR_DATA_BITS-1:0] PROCESS_NOISE_RST     = 32'd655;
   localparam logic [CSR_DATA_BITS-1:0] MEASUREMENT_NOISE_RST = 32'd65536;

   typedef enum logic {
      REG_PROCESS_NOISE,
      REG_MEASUREMENT_NOISE
   } csr_reg_type;

endpackage

### hw/rtl/skf_channels.sv
// Valid/ready channel interfaces for the scalar Kalman smoother.
// Depends on skf_pkg.
interface skf_req_if #(
   parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF
);
   import skf_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface skf_rsp_if;
   import skf_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [EST_BITS-1:0] estimate_out;

   modport source (output valid, output estimate_out, input ready);
   modport sink (input valid, input estimate_out, output ready);
endinterface

### hw/rtl/scalar_kalman_smoother.sv
// Scalar Kalman smoother: each transferred sample updates a signed Q16.16
// estimate and an unsigned variance; the new estimate is returned. The
// restoring gain divider resolves one quotient bit per cycle, after a setup
// step. A single multiplier then forms the estimate and variance products in
// turn, a final step writes back the variance and loads the output register,
// and the block is ready again in the cycle after that. A finished result sits
// in the output register, and the next sample is taken while it waits; the
// update only stalls at its last step if that register is full.
// process_noise sits at byte address 0, measurement_noise at 4.
// Depends on skf_pkg and skf_channels.
module scalar_kalman_smoother #(
   parameter int SAMPLE_BITS = skf_pkg::SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = skf_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   skf_req_if.sink                            req_port,
   skf_rsp_if.source                          rsp_port,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [skf_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [skf_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [skf_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);
   import skf_pkg::*;

   localparam int ONE_W  = FRAC_BITS + 1;
   localparam int SUM_W  = VAR_BITS + 1;
   localparam int DIFF_W = EST_BITS + 1;
   localparam int PROD_W = ONE_W + 1 + DIFF_W;
   localparam int SH_W   = PROD_W - FRAC_BITS;
   localparam int NEXT_W = SH_W + 1;
   localparam int CNT_W  = $clog2(FRAC_BITS + 2);
   localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_MUL_GAIN,
      ST_MUL_VAR,
      ST_DONE
   } state_type;

   state_type                     state_ff, state_in;
   logic [CSR_DATA_BITS-1:0]      pnoise_ff, pnoise_in;
   logic [CSR_DATA_BITS-1:0]      mnoise_ff, mnoise_in;
   logic signed [EST_BITS-1:0]    estimate_ff, estimate_in;
   logic [VAR_BITS-1:0]           variance_ff, variance_in;
   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in;
   logic [VAR_BITS-1:0]           pred_ff, pred_in;
   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic                          sum_zero_ff, sum_zero_in;
   logic [SUM_W-1:0]              rem_ff, rem_in;
   logic [ONE_W-1:0]              quo_ff, quo_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic signed [DIFF_W-1:0]      diff_ff, diff_in;
   logic [ONE_W-1:0]              gain_ff, gain_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [EST_BITS-1:0]    rsp_data_ff, rsp_data_in;

   logic                          csr_write;
   logic [SUM_W-1:0]              pred_sum;
   logic signed [DIFF_W-1:0]      target;
   logic [SUM_W:0]                trial;
   logic                          quo_bit;
   logic [ONE_W-1:0]              mul_a;
   logic signed [DIFF_W-1:0]      mul_b;
   logic signed [PROD_W-1:0]      mul_p;
   logic signed [SH_W-1:0]        shifted;
   logic signed [NEXT_W-1:0]      next_est;
   logic                          over_pos;
   logic                          over_neg;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      unique case (csr_reg_type'(paddr[2]))
         REG_PROCESS_NOISE:     prdata = pnoise_ff;
         REG_MEASUREMENT_NOISE: prdata = mnoise_ff;
      endcase
   end

   assign req_port.ready        = (state_ff == ST_IDLE);
   assign rsp_port.valid        = rsp_valid_ff;
   assign rsp_port.estimate_out = rsp_data_ff;

   // shared datapath pieces
   assign pred_sum = {1'b0, variance_ff} + {1'b0, pnoise_ff};
   assign target   = DIFF_W'(sample_ff) <<< FRAC_BITS;
   assign trial    = (cnt_ff == CNT_W'(FRAC_BITS + 1)) ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign quo_bit  = (trial >= {1'b0, sum_ff});

   always_comb begin
      if (state_ff == ST_MUL_VAR) begin
         mul_a = ONE - gain_ff;
         mul_b = DIFF_W'(signed'({1'b0, pred_ff}));
      end else begin
         mul_a = sum_zero_ff ? '0 : quo_ff;
         mul_b = diff_ff;
      end
   end

   assign mul_p    = PROD_W'(signed'({1'b0, mul_a})) * PROD_W'(mul_b);
   assign shifted  = SH_W'(prod_ff >>> FRAC_BITS);
   assign next_est = NEXT_W'(estimate_ff) + NEXT_W'(shifted);
   assign over_pos = !next_est[NEXT_W-1] && (|next_est[NEXT_W-2:EST_BITS-1]);
   assign over_neg = next_est[NEXT_W-1] && !(&next_est[NEXT_W-2:EST_BITS-1]);

   always_comb begin
      state_in     = state_ff;
      pnoise_in    = pnoise_ff;
      mnoise_in    = mnoise_ff;
      estimate_in  = estimate_ff;
      variance_in  = variance_ff;
      sample_in    = sample_ff;
      pred_in      = pred_ff;
      sum_in       = sum_ff;
      sum_zero_in  = sum_zero_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      cnt_in       = cnt_ff;
      diff_in      = diff_ff;
      gain_in      = gain_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_write) begin
         unique case (csr_reg_type'(paddr[2]))
            REG_PROCESS_NOISE:     pnoise_in = pwdata;
            REG_MEASUREMENT_NOISE: mnoise_in = pwdata;
         endcase
      end

      // drop the result once it is transferred
      if (rsp_valid_ff && rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_port.valid) begin
               sample_in = req_port.sample;
               pred_in   = pred_sum[VAR_BITS] ? '1 : pred_sum[VAR_BITS-1:0];
               state_in  = ST_PREP;
            end
         end
         ST_PREP: begin
            sum_in      = {1'b0, pred_ff} + {1'b0, mnoise_ff};
            sum_zero_in = (pred_ff == '0) && (mnoise_ff == '0);
            diff_in     = target - DIFF_W'(estimate_ff);
            rem_in      = {1'b0, pred_ff};
            quo_in      = '0;
            cnt_in      = CNT_W'(FRAC_BITS + 1);
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            quo_in = {quo_ff[ONE_W-2:0], quo_bit};
            rem_in = quo_bit ? SUM_W'(trial - {1'b0, sum_ff}) : trial[SUM_W-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_MUL_GAIN;
            end
         end
         ST_MUL_GAIN: begin
            gain_in  = mul_a;
            prod_in  = mul_p;
            state_in = ST_MUL_VAR;
         end
         ST_MUL_VAR: begin
            if (over_pos) begin
               estimate_in = {1'b0, {(EST_BITS-1){1'b1}}};
            end else if (over_neg) begin
               estimate_in = {1'b1, {(EST_BITS-1){1'b0}}};
            end else begin
               estimate_in = next_est[EST_BITS-1:0];
            end
            prod_in  = mul_p;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            variance_in = prod_ff[FRAC_BITS +: VAR_BITS];
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = estimate_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pnoise_ff    <= PROCESS_NOISE_RST;
         mnoise_ff    <= MEASUREMENT_NOISE_RST;
         estimate_ff  <= '0;
         variance_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pnoise_ff    <= pnoise_in;
         mnoise_ff    <= mnoise_in;
         estimate_ff  <= estimate_in;
         variance_ff  <= variance_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      pred_ff     <= pred_in;
      sum_ff      <= sum_in;
      sum_zero_ff <= sum_zero_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      diff_ff     <= diff_in;
      gain_ff     <= gain_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### hw/rtl/skf_checker.sv
// Port-level checks for the scalar Kalman smoother, bound to the top level.
// Depends on skf_pkg, skf_channels and scalar_kalman_smoother_defines.svh.
`include "scalar_kalman_smoother_defines.svh"

module skf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [skf_pkg::EST_BITS-1:0] estimate_out
);
   import skf_pkg::*;

   logic req_xfer;
   logic rsp_stall;

   assign req_xfer  = req_valid && req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;

   `SKF_ASSERT_ALWAYS(a_reset_clears_rsp, clock, reset, !rsp_valid, "result valid after reset")

   `SKF_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_xfer, !req_ready, "ready right after transfer")

   `SKF_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_xfer, !$rose(rsp_valid), "result too early")

   `SKF_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_stall, rsp_valid, "result dropped while stalled")

   `SKF_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(estimate_out), "result changed while stalled")

endmodule

bind scalar_kalman_smoother skf_checker u_skf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_port.valid),
   .req_ready    (req_port.ready),
   .rsp_valid    (rsp_port.valid),
   .rsp_ready    (rsp_port.ready),
   .estimate_out (rsp_port.estimate_out)
);
